// ===== hdl/grq_pkg.sv =====
// shared types, codes and sizes for the grouped request queue
package grq_pkg;

	localparam int GRQ_DEPTH = 128;
	localparam int STAMP_W   = 31;
	localparam int RANK_W    = 7;
	localparam int GS_W      = 7;

	localparam logic [1:0] OP_INSERT     = 2'd0;
	localparam logic [1:0] OP_DONE       = 2'd1;
	localparam logic [1:0] OP_LOOKUP     = 2'd2;
	// spare code, decoded as a lookup
	localparam logic [1:0] OP_LOOKUP_ALT = 2'd3;

	localparam logic [1:0] STS_OK   = 2'd0;
	localparam logic [1:0] STS_DUP  = 2'd1;
	localparam logic [1:0] STS_MISS = 2'd2;
	localparam logic [1:0] STS_FULL = 2'd3;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [STAMP_W-1:0] stamp;
		logic [RANK_W-1:0]  requester;
	} grq_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [6:0] position;
		logic [6:0] group_index;
		logic       group_filled;
		logic [7:0] entry_total;
	} grq_rsp_t;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [RANK_W-1:0]  rank;
		logic               done;
	} grq_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH,
		ST_SH_RD,
		ST_SHIFT,
		ST_INS_WR,
		ST_CP_RD,
		ST_CP,
		ST_RESP
	} grq_state_t;

endpackage

// ===== hdl/grouped_request_queue_top.sv =====
// grouped request queue: sorted request table with group compaction
//
// input: a word (req) is taken at a clock edge with start high and busy low.
// busy stays high until the result has been shown.
// output: result_valid is high for exactly one cycle with the result word;
// the receiver cannot stall, so the result is simply presented once.
// config: group_size_wdata is written when group_size_we is high; write it only
// while busy is low (not enforced by the block); group size zero acts as one.
// phases of each word:
//   lookup, duplicate, full or missing entry: search walk only
//   insert: search walk, then a shift when entries move, then the entry write
//   done: one search walk plus one compaction pass
// every phase walks the table through the single ram read port, one entry
// per cycle.
// reset empties the table at once; no clearing pass is needed because only
// positions below the entry count are ever used.
module grouped_request_queue_top import grq_pkg::*; #(
	parameter int TABLE_DEPTH = GRQ_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  grq_req_t        req,
	input  logic            group_size_we,
	input  logic [GS_W-1:0] group_size_wdata,
	output logic            result_valid,
	output grq_rsp_t        result
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [GS_W-1:0] group_size_q;
	logic [GS_W-1:0] group_k;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	grq_entry_t      ram_wdata, ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= GS_W'(1);
		end else if (group_size_we) begin
			group_size_q <= group_size_wdata;
		end
	end

	assign group_k = (group_size_q == '0) ? GS_W'(1) : group_size_q;

	grq_ram #(
		.WIDTH ($bits(grq_entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	grq_seq #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req          (req),
		.group_k      (group_k),
		.busy         (busy),
		.result_valid (result_valid),
		.result       (result),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

endmodule

// ===== hdl/grq_ram.sv =====
// generic single write port ram with registered read
module grq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/grq_seq.sv =====
// sequencer: sorted search, insert shift and group compaction over one ram
module grq_seq import grq_pkg::*; #(
	parameter int TABLE_DEPTH = GRQ_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  grq_req_t                       req,
	input  logic [GS_W-1:0]                group_k,
	output logic                           busy,
	output logic                           result_valid,
	output grq_rsp_t                       result,
	output logic                           ram_we,
	output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
	output grq_entry_t                     ram_wdata,
	output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
	input  grq_entry_t                     ram_rdata
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = ((CW > GS_W) ? CW : GS_W) + 1;

	grq_state_t state_q, state_nx;

	logic [1:0]         op_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [RANK_W-1:0]  rank_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      pos_q;
	logic [CW-1:0]      gidx_q;
	logic [GS_W-1:0]    gcnt_q;
	logic [CW-1:0]      rp_q;
	logic [CW-1:0]      wp_q;
	logic               all_q;
	logic [AW-1:0]      ptr_q;
	logic [1:0]         sts_q;
	logic [6:0]         rpos_q;
	logic [6:0]         rgrp_q;
	logic               rfill_q;

	logic          at_end, below, hit, full, grp_end, done_bit, ins_ok, filled;
	logic [CW-1:0] base, cnt_after;

	assign at_end  = (pos_q == count_q);
	assign below   = !at_end && ((ram_rdata.stamp < stamp_q) ||
		((ram_rdata.stamp == stamp_q) && (ram_rdata.rank < rank_q)));
	assign hit     = !at_end && (ram_rdata.stamp == stamp_q) && (ram_rdata.rank == rank_q);
	assign full    = (count_q == CW'(TABLE_DEPTH));
	assign ins_ok  = (op_q == OP_INSERT) && !hit && !full;
	assign grp_end = ({1'b0, gcnt_q} + 1'b1) == {1'b0, group_k};
	assign done_bit = ram_rdata.done | (rp_q == pos_q);

	// group base plus k against the count the entry will see
	assign base      = pos_q - CW'(gcnt_q);
	assign cnt_after = ins_ok ? count_q + 1'b1 : count_q;
	assign filled    = (SW'(base) + SW'(group_k)) <= SW'(cnt_after);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nx = ST_SRCH;
				end
			end
			ST_SRCH: begin
				if (!below) begin
					if (op_q == OP_INSERT) begin
						if (hit || full) begin
							state_nx = ST_RESP;
						end else if (at_end) begin
							state_nx = ST_INS_WR;
						end else begin
							state_nx = ST_SH_RD;
						end
					end else if (op_q == OP_DONE && hit) begin
						state_nx = ST_CP_RD;
					end else begin
						state_nx = ST_RESP;
					end
				end
			end
			ST_SH_RD:  state_nx = ST_SHIFT;
			ST_SHIFT: begin
				if (ptr_q == AW'(pos_q)) begin
					state_nx = ST_INS_WR;
				end
			end
			ST_INS_WR: state_nx = ST_RESP;
			ST_CP_RD:  state_nx = ST_CP;
			ST_CP: begin
				if (rp_q == count_q) begin
					state_nx = ST_RESP;
				end
			end
			ST_RESP:   state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = ram_rdata;
		ram_raddr = '0;
		case (state_q)
			ST_SRCH:  ram_raddr = AW'(pos_q + 1'b1);
			ST_SH_RD: ram_raddr = AW'(count_q - 1'b1);
			ST_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q + 1'b1;
				ram_raddr = ptr_q - 1'b1;
			end
			ST_INS_WR: begin
				ram_we          = 1'b1;
				ram_waddr       = AW'(pos_q);
				ram_wdata.stamp = stamp_q;
				ram_wdata.rank  = rank_q;
				ram_wdata.done  = 1'b0;
			end
			ST_CP: begin
				ram_we         = (rp_q != count_q);
				ram_waddr      = AW'(wp_q);
				ram_wdata.done = done_bit;
				ram_raddr      = AW'(rp_q + 1'b1);
			end
			default: ram_raddr = '0;
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_RESP);
	always_comb begin
		result.status       = sts_q;
		result.position     = rpos_q;
		result.group_index  = rgrp_q;
		result.group_filled = rfill_q;
		result.entry_total  = 8'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_INS_WR) begin
				count_q <= count_q + 1'b1;
			end else if (state_q == ST_CP && rp_q == count_q) begin
				count_q <= wp_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q    <= req.req_type;
				stamp_q <= req.stamp;
				rank_q  <= req.requester;
				pos_q   <= '0;
				gidx_q  <= '0;
				gcnt_q  <= '0;
			end
			ST_SRCH: begin
				if (below) begin
					pos_q <= pos_q + 1'b1;
					if (grp_end) begin
						gcnt_q <= '0;
						gidx_q <= gidx_q + 1'b1;
					end else begin
						gcnt_q <= gcnt_q + 1'b1;
					end
				end else begin
					if (op_q == OP_INSERT && !hit && full) begin
						sts_q   <= STS_FULL;
						rpos_q  <= '0;
						rgrp_q  <= '0;
						rfill_q <= 1'b0;
					end else if (op_q != OP_INSERT && !hit) begin
						sts_q   <= STS_MISS;
						rpos_q  <= '0;
						rgrp_q  <= '0;
						rfill_q <= 1'b0;
					end else begin
						sts_q   <= (op_q == OP_INSERT && hit) ? STS_DUP : STS_OK;
						rpos_q  <= 7'(pos_q);
						rgrp_q  <= 7'(gidx_q);
						rfill_q <= filled;
					end
				end
			end
			ST_SH_RD: ptr_q <= AW'(count_q - 1'b1);
			ST_SHIFT: ptr_q <= ptr_q - 1'b1;
			ST_CP_RD: begin
				rp_q   <= '0;
				wp_q   <= '0;
				gcnt_q <= '0;
				all_q  <= 1'b1;
			end
			ST_CP: begin
				if (rp_q != count_q) begin
					rp_q <= rp_q + 1'b1;
					if (grp_end) begin
						gcnt_q <= '0;
						all_q  <= 1'b1;
						// a whole done group is dropped by rewinding the write pointer
						wp_q <= (all_q && done_bit) ?
							CW'(SW'(wp_q) + 1'b1 - SW'(group_k)) : wp_q + 1'b1;
					end else begin
						gcnt_q <= gcnt_q + 1'b1;
						all_q  <= all_q & done_bit;
						wp_q   <= wp_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_wp_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CP) |-> (wp_q <= rp_q))
		else $error("compaction write pointer passed read pointer");

	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_start_search: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_SRCH))
		else $error("accepted word did not start a search");

endmodule

// ===== tb/grq_checker.sv =====
// checker for the grouped request queue: predicts each result word and compares
`timescale 1ns / 100ps
module grq_checker import grq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  grq_req_t        req,
	input  logic            group_size_we,
	input  logic [GS_W-1:0] group_size_wdata,
	input  logic            result_valid,
	input  grq_rsp_t        result,
	output int              errors,
	output int              pending
);

	logic [STAMP_W-1:0] tab_stamp [GRQ_DEPTH];
	logic [RANK_W-1:0]  tab_rank  [GRQ_DEPTH];
	logic               tab_done  [GRQ_DEPTH];
	int                 tab_count;
	int                 gsize;
	grq_rsp_t           rsp_q [$];
	int                 err_cnt;

	task automatic report(input string field, input int got, input int want);
		$display("%0t mismatch on %s: got %0d expected %0d", $time, field, got, want);
		err_cnt++;
	endtask

	// true when entry i sorts below the key
	function automatic bit below(input int i, input logic [STAMP_W-1:0] st,
			input logic [RANK_W-1:0] rk);
		if (tab_stamp[i] != st) return tab_stamp[i] < st;
		return tab_rank[i] < rk;
	endfunction

	task automatic compact();
		int k, b, i;
		bit changed, all;
		k = (gsize == 0) ? 1 : gsize;
		changed = 1;
		while (changed) begin
			changed = 0;
			for (b = 0; (b + 1) * k <= tab_count && !changed; b++) begin
				all = 1;
				for (i = b * k; i < b * k + k; i++)
					if (!tab_done[i]) all = 0;
				if (all) begin
					for (i = b * k; i < tab_count - k; i++) begin
						tab_stamp[i] = tab_stamp[i + k];
						tab_rank[i]  = tab_rank[i + k];
						tab_done[i]  = tab_done[i + k];
					end
					tab_count -= k;
					changed = 1;
				end
			end
		end
	endtask

	task automatic predict(input grq_req_t w, output grq_rsp_t r);
		int k, p, i, pos, grp;
		bit found, show;
		k = (gsize == 0) ? 1 : gsize;
		p = 0;
		while (p < tab_count && below(p, w.stamp, w.requester)) p++;
		found = p < tab_count && tab_stamp[p] == w.stamp && tab_rank[p] == w.requester;
		r = '0;
		show = 0;
		pos = 0;
		grp = 0;
		if (w.req_type == OP_INSERT) begin
			if (found) begin
				r.status = STS_DUP;
				show = 1;
			end else if (tab_count >= GRQ_DEPTH) begin
				r.status = STS_FULL;
			end else begin
				for (i = tab_count; i > p; i--) begin
					tab_stamp[i] = tab_stamp[i - 1];
					tab_rank[i]  = tab_rank[i - 1];
					tab_done[i]  = tab_done[i - 1];
				end
				tab_stamp[p] = w.stamp;
				tab_rank[p]  = w.requester;
				tab_done[p]  = 0;
				tab_count++;
				r.status = STS_OK;
				show = 1;
			end
		end else if (!found) begin
			r.status = STS_MISS;
		end else begin
			r.status = STS_OK;
			show = 1;
		end
		if (show) begin
			pos = p;
			grp = p / k;
			r.position = pos[6:0];
			r.group_index = grp[6:0];
			r.group_filled = (grp + 1) * k <= tab_count;
		end
		if (w.req_type == OP_DONE && found) begin
			tab_done[p] = 1;
			compact();
		end
		r.entry_total = tab_count[7:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		grq_rsp_t want, r;
		if (!arst_n) begin
			tab_count = 0;
			gsize = 1;
			rsp_q.delete();
			err_cnt = 0;
			pending <= 0;
			errors <= 0;
		end else begin
			if (result_valid) begin
				if (rsp_q.size() == 0) begin
					report("result_valid", 1, 0);
				end else begin
					want = rsp_q.pop_front();
					if (result.status != want.status)
						report("status", result.status, want.status);
					if (result.position != want.position)
						report("position", result.position, want.position);
					if (result.group_index != want.group_index)
						report("group_index", result.group_index, want.group_index);
					if (result.group_filled != want.group_filled)
						report("group_filled", result.group_filled, want.group_filled);
					if (result.entry_total != want.entry_total)
						report("entry_total", result.entry_total, want.entry_total);
				end
			end
			if (group_size_we)
				gsize = group_size_wdata;
			if (start && !busy) begin
				predict(req, r);
				rsp_q.push_back(r);
			end
			pending <= rsp_q.size();
			errors <= err_cnt;
		end
	end

endmodule

// ===== tb/testbench.sv =====
// top of the grouped request queue testbench: stimulus, configuration and verdict
`timescale 1ns / 100ps
module testbench;
	import grq_pkg::*;

	logic            clk = 0;
	logic            arst_n = 0;
	logic            start = 0;
	logic            busy;
	grq_req_t        req = '0;
	logic            group_size_we = 0;
	logic [GS_W-1:0] group_size_wdata = '0;
	logic            result_valid;
	grq_rsp_t        result;
	int              errors, pending;
	bit              quiet_run = 0;

	always #5 clk = ~clk;

	grouped_request_queue_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.group_size_we(group_size_we), .group_size_wdata(group_size_wdata),
		.result_valid(result_valid), .result(result)
	);

	grq_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.group_size_we(group_size_we), .group_size_wdata(group_size_wdata),
		.result_valid(result_valid), .result(result),
		.errors(errors), .pending(pending)
	);

	task automatic send(input logic [1:0] op, input int st, input int rk);
		start <= 1;
		req <= '{req_type: op, stamp: STAMP_W'(st), requester: RANK_W'(rk)};
		do @(posedge clk); while (busy);
		if (!quiet_run && $urandom_range(0, 3) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_group(input logic [GS_W-1:0] gs);
		drain();
		group_size_we <= 1;
		group_size_wdata <= gs;
		@(posedge clk);
		group_size_we <= 0;
	endtask

	// mostly small keys so hits, duplicates and a full table occur
	task automatic rand_item(input int ins_wt);
		logic [1:0] op;
		logic [STAMP_W-1:0] st;
		logic [RANK_W-1:0] rk;
		int r;
		r = $urandom_range(0, 99);
		op = (r < ins_wt) ? OP_INSERT : (r < ins_wt + (100 - ins_wt) * 2 / 3) ? OP_DONE
			: ($urandom_range(0, 1) == 0) ? OP_LOOKUP : OP_LOOKUP_ALT;
		if ($urandom_range(0, 9) == 0) begin
			st = STAMP_W'($urandom);
			rk = RANK_W'($urandom);
		end else begin
			st = STAMP_W'($urandom_range(0, 15));
			rk = RANK_W'($urandom_range(0, 7));
			if ($urandom_range(0, 15) == 0) st = {STAMP_W{1'b1}} - st;
		end
		send(op, int'(st), int'(rk));
	endtask

	initial begin
		logic [STAMP_W-1:0] smax;
		logic [RANK_W-1:0]  rmax;
		smax = '1;
		rmax = '1;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: empty table, extremes, duplicate, lookups, done, type three
		send(OP_LOOKUP, 0, 0);
		send(OP_DONE, 5, 5);
		send(OP_INSERT, smax, rmax);
		send(OP_INSERT, 0, 0);
		send(OP_INSERT, 0, rmax);
		send(OP_INSERT, smax, 0);
		send(OP_INSERT, 0, 0);
		send(OP_LOOKUP, smax, 0);
		send(OP_LOOKUP_ALT, 0, rmax);
		send(OP_LOOKUP, 1, 1);
		send(OP_DONE, 0, 0);
		send(OP_DONE, smax, rmax);
		send(OP_DONE, 0, 0);
		set_group(7'd2);
		send(OP_INSERT, 3, 3);
		send(OP_DONE, 0, rmax);
		send(OP_LOOKUP, 3, 3);
		send(OP_DONE, smax, 0);
		send(OP_DONE, 3, 3);
		set_group(7'd0);
		send(OP_LOOKUP, 0, rmax);
		send(OP_DONE, 0, rmax);
		// random phases over several group sizes
		set_group(7'd1);
		repeat (60) rand_item(50);
		set_group(7'd3);
		repeat (60) rand_item(55);
		// wait for everything outstanding mid-phase
		drain();
		repeat (20) rand_item(55);
		set_group(7'd64);
		repeat (170) rand_item(85);
		repeat (60) rand_item(20);
		set_group(7'd127);
		repeat (40) rand_item(50);
		set_group(GS_W'($urandom_range(4, 12)));
		repeat (50) rand_item(55);
		set_group(7'd0);
		quiet_run = 1;
		repeat (40) rand_item(45);
		drain();
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
